### src/autoscaling_request_dispatcher_core_defines.svh
// Assertion macros shared by the dispatcher RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef AUTOSCALING_REQUEST_DISPATCHER_CORE_DEFINES_SVH
`define AUTOSCALING_REQUEST_DISPATCHER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("asrd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("asrd assertion failed");

`endif

### src/asrd_pkg.sv
// Package for the autoscaling request dispatcher: defaults, codes and shared types.
// No dependencies.
package asrd_pkg;

    localparam int MAX_WORKERS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF   = 1024;
    localparam int DURATION_BITS_DEF = 16;

    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_SCALE    = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [1:0] CFG_MIN_QUEUE  = 2'd0;
    localparam logic [1:0] CFG_MAX_QUEUE  = 2'd1;
    localparam logic [1:0] CFG_INIT_SERV  = 2'd2;

    localparam logic [10:0] MAX_QUEUE_RESET = 11'd4;
    localparam logic [15:0] PENDING_MAX     = 16'hFFFF;
    localparam int          OUT_BITS        = 176;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DISP = 7'b0000010,
        S_FIND = 7'b0000100,
        S_SC0  = 7'b0001000,
        S_SC1  = 7'b0010000,
        S_GROW = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

endpackage

### src/asrd_fifo.sv
// Request FIFO built on a synchronous memory with a registered head read.
// Depends on asrd_pkg for the control struct.
module asrd_fifo #(
    parameter int QUEUE_DEPTH   = asrd_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = asrd_pkg::DURATION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  asrd_pkg::t_fifo_ctl                i_ctl,
    input  logic [DURATION_BITS-1:0]           i_wdata,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output logic [DURATION_BITS-1:0]           o_head_data
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    logic [DURATION_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]            r_head;
    logic [AW-1:0]            n_head;
    logic [AW-1:0]            r_tail;
    logic [CW-1:0]            r_count;
    logic [DURATION_BITS-1:0] r_rd;

    always_comb begin
        n_head = r_head;
        if (i_ctl.pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head <= n_head;
            if (i_ctl.push) begin
                r_tail  <= (r_tail == LAST) ? '0 : r_tail + AW'(1);
                r_count <= r_count + CW'(1);
            end else if (i_ctl.pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (r_tail == n_head)) begin
            r_rd <= i_wdata;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

    assign o_count     = r_count;
    assign o_head_data = r_rd;
endmodule

### src/autoscaling_request_dispatcher_core.sv
// Top level of the autoscaling request dispatcher: worker pool, scaling and status.
// Depends on asrd_pkg, asrd_fifo and autoscaling_request_dispatcher_core_defines.svh.
//
// Channel   Direction  Signals                         Content
// s         in         i_s_tvalid/o_s_tready           tuser opcode, tdata duration
// m         out        o_m_tvalid/i_m_tready           tdata status word
// cfg       in         i_cfg_we/i_cfg_addr/i_cfg_wdata register write
//
// Enqueue and the no-op go from accept straight to the done state and then to the output register.
// A dispatch pass walks the worker table one entry per cycle and the FIFO head read is registered;
// deferred removals follow the walk, searching for idle workers from the top index down.
// A scaling step passes through S_SC0 and S_SC1, then S_GROW or S_FIND if needed, before S_DONE;
// a growth loop adds one worker per step, and a removal searches workers from the top index down.
// Reset is synchronous and clears all control state; the FIFO memory is not cleared.
// A finished result waits in the output register while the next transaction is accepted.
`include "autoscaling_request_dispatcher_core_defines.svh"

module autoscaling_request_dispatcher_core #(
    parameter int MAX_WORKERS   = asrd_pkg::MAX_WORKERS_DEF,
    parameter int QUEUE_DEPTH   = asrd_pkg::QUEUE_DEPTH_DEF,
    parameter int DURATION_BITS = asrd_pkg::DURATION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // duration[15:0]
    input  logic [1:0]                    i_s_tuser,  // opcode[1:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // dispatched[0], completed_now[5:1], dropped[6], worker_count[11:7],
    // busy_count[16:12], queue_length[27:17], pending_removals[43:28],
    // total_accepted[75:44], total_handled[107:76], total_added[139:108],
    // total_removed[171:140], zero fill[175:172]
    output logic [asrd_pkg::OUT_BITS-1:0] o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [10:0]                   i_cfg_wdata
);
    localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int PW = $clog2(MAX_WORKERS + 1);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DB = DURATION_BITS;
    localparam int MW = PW + 11;
    localparam logic [PW-1:0] MAXW = PW'(MAX_WORKERS);

    asrd_pkg::t_state r_state, n_state;

    logic [DB-1:0]  r_rem  [MAX_WORKERS];
    logic           r_busy [MAX_WORKERS];
    logic [PW-1:0]  r_pool;
    logic [PW-1:0]  r_busy_cnt;
    logic [IW-1:0]  r_idx;
    logic [15:0]    r_pending;
    logic [31:0]    r_acc, r_hand, r_add, r_rmv;
    logic [10:0]    r_min, r_max;
    logic [MW-1:0]  r_pmax, r_pmin;
    logic           r_disp, r_drop, r_from_disp;
    logic [PW-1:0]  r_comp;
    logic           r_out_valid;
    logic [asrd_pkg::OUT_BITS-1:0] r_out_data;

    asrd_pkg::t_fifo_ctl fifo_ctl;
    logic [CW-1:0]  fifo_count;
    logic [DB-1:0]  fifo_head;
    logic [DB-1:0]  in_dur;
    logic           in_acc;
    logic           out_load;
    logic           idx_last;
    logic           cur_busy;
    logic [DB-1:0]  cur_rem;
    logic           pool_full;
    logic [4:0]     cfg_pool;

    asrd_fifo #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fifo_ctl),
        .i_wdata     (in_dur),
        .o_count     (fifo_count),
        .o_head_data (fifo_head)
    );

    assign in_dur     = DB'(i_s_tdata);
    assign o_s_tready = (r_state == asrd_pkg::S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == asrd_pkg::S_DONE) && (!r_out_valid || i_m_tready);
    assign idx_last   = ((PW'(r_idx) + PW'(1)) == r_pool);
    assign cur_busy   = r_busy[r_idx];
    assign cur_rem    = r_rem[r_idx];
    assign pool_full  = (r_pool >= MAXW);
    assign cfg_pool   = i_cfg_wdata[4:0];

    always_comb begin
        fifo_ctl.push = in_acc && (i_s_tuser == asrd_pkg::OP_ENQUEUE)
                        && (32'(fifo_count) < 32'(QUEUE_DEPTH));
        fifo_ctl.pop  = (r_state == asrd_pkg::S_DISP) && !cur_busy && (fifo_count != '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            asrd_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_s_tuser)
                        asrd_pkg::OP_DISPATCH: n_state = (r_pool == '0) ?
                            asrd_pkg::S_DONE : asrd_pkg::S_DISP;
                        asrd_pkg::OP_SCALE:    n_state = asrd_pkg::S_SC0;
                        default:               n_state = asrd_pkg::S_DONE;
                    endcase
                end
            end
            asrd_pkg::S_DISP: begin
                if (idx_last) begin
                    n_state = (r_pending != '0) ? asrd_pkg::S_FIND : asrd_pkg::S_DONE;
                end
            end
            asrd_pkg::S_FIND: begin
                if (!cur_busy) begin
                    n_state = (r_from_disp && (r_pending != 16'd1) && (r_idx != '0)) ?
                        asrd_pkg::S_FIND : asrd_pkg::S_DONE;
                end else if (r_idx == '0) begin
                    n_state = asrd_pkg::S_DONE;
                end
            end
            asrd_pkg::S_SC0: n_state = asrd_pkg::S_SC1;
            asrd_pkg::S_SC1: begin
                n_state = asrd_pkg::S_DONE;
                if (r_pool != '0) begin
                    if (32'(fifo_count) > 32'(r_pmax)) begin
                        if (r_max != '0) begin
                            n_state = asrd_pkg::S_GROW;
                        end
                    end else if (32'(fifo_count) < 32'(r_pmin)) begin
                        n_state = asrd_pkg::S_FIND;
                    end
                end
            end
            asrd_pkg::S_GROW: begin
                if (pool_full || !(32'(fifo_count) > 32'(r_pmax))) begin
                    n_state = asrd_pkg::S_DONE;
                end
            end
            asrd_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = asrd_pkg::S_IDLE;
                end
            end
            default: n_state = asrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asrd_pkg::S_IDLE;
            r_pool      <= PW'(1);
            r_busy_cnt  <= '0;
            r_idx       <= '0;
            r_pending   <= '0;
            r_acc       <= '0;
            r_hand      <= '0;
            r_add       <= '0;
            r_rmv       <= '0;
            r_min       <= '0;
            r_max       <= asrd_pkg::MAX_QUEUE_RESET;
            r_disp      <= 1'b0;
            r_drop      <= 1'b0;
            r_comp      <= '0;
            r_from_disp <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_WORKERS; j++) begin
                r_rem[j]  <= '0;
                r_busy[j] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    asrd_pkg::CFG_MIN_QUEUE: r_min <= i_cfg_wdata;
                    asrd_pkg::CFG_MAX_QUEUE: r_max <= i_cfg_wdata;
                    asrd_pkg::CFG_INIT_SERV: begin
                        r_pool     <= (32'(cfg_pool) > 32'(MAX_WORKERS)) ? MAXW : PW'(cfg_pool);
                        r_busy_cnt <= '0;
                        for (int j = 0; j < MAX_WORKERS; j++) begin
                            r_rem[j]  <= '0;
                            r_busy[j] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            case (r_state)
                asrd_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_disp      <= 1'b0;
                        r_comp      <= '0;
                        r_drop      <= 1'b0;
                        r_idx       <= '0;
                        r_from_disp <= 1'b1;
                        if (i_s_tuser == asrd_pkg::OP_ENQUEUE) begin
                            if (fifo_ctl.push) begin
                                r_acc <= r_acc + 32'd1;
                            end else begin
                                r_drop <= 1'b1;
                            end
                        end
                    end
                end
                asrd_pkg::S_DISP: begin
                    if (cur_busy) begin
                        if (cur_rem <= DB'(1)) begin
                            r_rem[r_idx]  <= '0;
                            r_busy[r_idx] <= 1'b0;
                            r_comp        <= r_comp + PW'(1);
                            r_hand        <= r_hand + 32'd1;
                            r_busy_cnt    <= r_busy_cnt - PW'(1);
                        end else begin
                            r_rem[r_idx] <= cur_rem - DB'(1);
                        end
                    end else if (fifo_ctl.pop) begin
                        r_rem[r_idx]  <= fifo_head;
                        r_busy[r_idx] <= 1'b1;
                        r_disp        <= 1'b1;
                        r_busy_cnt    <= r_busy_cnt + PW'(1);
                    end
                    if (idx_last) begin
                        r_idx <= IW'(r_pool - PW'(1));
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                asrd_pkg::S_FIND: begin
                    if (!cur_busy) begin
                        for (int j = 0; j < MAX_WORKERS - 1; j++) begin
                            if (j >= int'(r_idx)) begin
                                r_rem[j]  <= r_rem[j+1];
                                r_busy[j] <= r_busy[j+1];
                            end
                        end
                        r_rem[MAX_WORKERS-1]  <= '0;
                        r_busy[MAX_WORKERS-1] <= 1'b0;
                        r_pool <= r_pool - PW'(1);
                        r_rmv  <= r_rmv + 32'd1;
                        if (r_from_disp) begin
                            r_pending <= r_pending - 16'd1;
                        end
                        r_idx <= r_idx - IW'(1);
                    end else if (r_idx == '0) begin
                        if (!r_from_disp && (r_pending != asrd_pkg::PENDING_MAX)) begin
                            r_pending <= r_pending + 16'd1;
                        end
                    end else begin
                        r_idx <= r_idx - IW'(1);
                    end
                end
                asrd_pkg::S_SC0: begin
                    r_from_disp <= 1'b0;
                    r_pmax      <= MW'(r_pool) * MW'(r_max);
                    r_pmin      <= MW'(r_pool) * MW'(r_min);
                end
                asrd_pkg::S_SC1: begin
                    r_idx <= IW'(r_pool - PW'(1));
                    if (r_pool == '0) begin
                        if (fifo_count != '0) begin
                            r_pool <= r_pool + PW'(1);
                            r_add  <= r_add + 32'd1;
                        end
                    end else if ((32'(fifo_count) > 32'(r_pmax)) && (r_max == '0)) begin
                        if (!pool_full) begin
                            r_pool <= r_pool + PW'(1);
                            r_add  <= r_add + 32'd1;
                        end
                    end
                end
                asrd_pkg::S_GROW: begin
                    if (!pool_full && (32'(fifo_count) > 32'(r_pmax))) begin
                        r_pool <= r_pool + PW'(1);
                        r_add  <= r_add + 32'd1;
                        r_pmax <= r_pmax + MW'(r_max);
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {4'b0, r_rmv, r_add, r_hand, r_acc, r_pending,
                           11'(fifo_count), 5'(r_busy_cnt), 5'(r_pool), r_drop,
                           5'(r_comp), r_disp};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `ASRD_ASSERT_SAME(a_busy_in_pool, 1'b1, r_busy_cnt <= r_pool)
    `ASRD_ASSERT_SAME(a_pool_bound, 1'b1, r_pool <= MAXW)
    `ASRD_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != asrd_pkg::S_IDLE)
    `ASRD_ASSERT_SAME(a_no_push_pop, 1'b1, !(fifo_ctl.push && fifo_ctl.pop))
endmodule
